>>> src/assert_macros.svh
// Assertion macros used by the port-level checker of the scan sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, quiet while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> src/dass_pkg.sv
// Types, codes and constants of the dual converter scan sequencer.
`default_nettype none

package dass_pkg;

	// Scan geometry
	localparam int CHANNELS    = 4;
	localparam int CHAN_W      = 2;
	localparam int CACHE_DEPTH = 8;
	localparam int CACHE_AW    = 3;

	// Config register high byte by channel
	localparam logic [7:0] MSB_TABLE [4] = '{8'hC7, 8'hD7, 8'hE7, 8'hF7};

	// Configuration register indexes
	localparam logic [7:0] REG_ENABLED    = 8'd0;
	localparam logic [7:0] REG_ADDR_A     = 8'd1;
	localparam logic [7:0] REG_ADDR_B     = 8'd2;
	localparam logic [7:0] REG_CONVERT_MS = 8'd3;

	typedef enum logic [1:0] {
		OP_POLL      = 2'd0,
		OP_DONE      = 2'd1,
		OP_ERROR     = 2'd2,
		OP_HOST_READ = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CMD_NONE    = 2'd0,
		CMD_CONFIG  = 2'd1,
		CMD_POINTER = 2'd2,
		CMD_READ    = 2'd3
	} cmd_t;

	typedef struct packed {
		logic       enabled;
		logic [6:0] addr_a;
		logic [6:0] addr_b;
		logic [7:0] convert_ms;
	} cfg_t;

	typedef struct packed {
		op_t                 op;
		logic [31:0]         now_ms;
		logic [15:0]         rx_data;
		logic signed [7:0]   error_code;
		logic [CACHE_AW-1:0] read_index;
	} item_t;

	typedef struct packed {
		cmd_t                cmd_kind;
		logic [6:0]          cmd_addr;
		logic [7:0]          cmd_config_msb;
		logic                cache_write;
		logic [CACHE_AW-1:0] cache_index;
		logic [15:0]         cache_value;
		logic                busy;
		logic                err_seen;
		logic signed [7:0]   last_error;
	} res_t;

endpackage

`default_nettype wire

>>> src/dass_cache.sv
// Eight-word result cache: one write port, one read port.
`default_nettype none

module dass_cache (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [dass_pkg::CACHE_AW-1:0] wr_index,
	input  wire logic [15:0]                   wr_data,
	input  wire logic [dass_pkg::CACHE_AW-1:0] rd_index,
	output logic [15:0]                        rd_data
);
	import dass_pkg::*;

	logic [15:0] words_q [CACHE_DEPTH];

	// Store a conversion result; all words clear at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CACHE_DEPTH; i++) begin
				words_q[i] <= '0;
			end
		end else if (wr_en) begin
			words_q[wr_index] <= wr_data;
		end
	end

	// Select the host word
	assign rd_data = words_q[rd_index];

endmodule

`default_nettype wire

>>> src/dass_seq.sv
// Scan sequencer state and per-word step logic.
`default_nettype none

module dass_seq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire dass_pkg::cfg_t  cfg,
	input  wire dass_pkg::item_t item,
	input  wire logic            fire,
	output dass_pkg::res_t       res
);
	import dass_pkg::*;

	typedef enum logic [2:0] {
		PH_CONFIG  = 3'd0,
		PH_POINTER = 3'd1,
		PH_WAIT    = 3'd2,
		PH_READ    = 3'd3,
		PH_CACHE   = 3'd4
	} phase_t;

	phase_t            phase_q, phase_d;
	logic              dev_sel_q, dev_sel_d;
	logic [CHAN_W-1:0] chan_q, chan_d;
	logic [31:0]       wait_start_q, wait_start_d;
	logic              pending_q, pending_d;
	logic              err_flag_q, err_flag_d;
	logic signed [7:0] err_code_q, err_code_d;
	logic [15:0]       read_buf_q;
	logic              capture;
	logic [6:0]        dev_addr;
	logic [31:0]       elapsed;
	logic [CHAN_W-1:0] chan_next;

	assign dev_addr  = dev_sel_q ? cfg.addr_b : cfg.addr_a;
	assign elapsed   = item.now_ms - wait_start_q;
	assign chan_next = (chan_q == CHAN_W'(CHANNELS - 1)) ? '0 : chan_q + 1'b1;
	assign capture   = (item.op == OP_DONE) && pending_q && (phase_q == PH_CACHE);

	// Work out the next state and the result word for the item in hand
	always_comb begin
		phase_d      = phase_q;
		dev_sel_d    = dev_sel_q;
		chan_d       = chan_q;
		wait_start_d = wait_start_q;
		pending_d    = pending_q;
		err_flag_d   = err_flag_q;
		err_code_d   = err_code_q;
		res          = '0;
		res.cmd_kind = CMD_NONE;

		case (item.op)
			OP_POLL: begin
				if (cfg.enabled && !pending_q) begin
					case (phase_q)
						PH_CONFIG: begin
							pending_d          = 1'b1;
							res.cmd_kind       = CMD_CONFIG;
							res.cmd_addr       = dev_addr;
							res.cmd_config_msb = MSB_TABLE[chan_q];
							dev_sel_d          = !dev_sel_q;
							if (dev_sel_q) begin
								phase_d = PH_POINTER;
							end
						end
						PH_POINTER: begin
							pending_d    = 1'b1;
							res.cmd_kind = CMD_POINTER;
							res.cmd_addr = dev_addr;
							dev_sel_d    = !dev_sel_q;
							if (dev_sel_q) begin
								wait_start_d = item.now_ms;
								phase_d      = PH_WAIT;
							end
						end
						PH_WAIT: begin
							if (elapsed > {24'd0, cfg.convert_ms}) begin
								phase_d = PH_READ;
							end
						end
						PH_READ: begin
							pending_d    = 1'b1;
							res.cmd_kind = CMD_READ;
							res.cmd_addr = dev_addr;
							phase_d      = PH_CACHE;
						end
						PH_CACHE: begin
							res.cache_write = 1'b1;
							res.cache_value = read_buf_q;
							dev_sel_d       = !dev_sel_q;
							if (!dev_sel_q) begin
								res.cache_index = CACHE_AW'(chan_q);
								phase_d         = PH_READ;
							end else begin
								res.cache_index = CACHE_AW'(chan_q) + CACHE_AW'(CHANNELS);
								chan_d          = chan_next;
								phase_d         = PH_CONFIG;
							end
						end
						default: begin
							phase_d = PH_CONFIG;
						end
					endcase
				end
			end
			OP_DONE: begin
				pending_d = 1'b0;
			end
			OP_ERROR: begin
				pending_d  = 1'b0;
				err_flag_d = 1'b1;
				err_code_d = item.error_code;
			end
			default: begin
			end
		endcase

		res.busy       = pending_d;
		res.err_seen   = err_flag_d;
		res.last_error = err_code_d;
	end

	// Advance the sequencer once per word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_CONFIG;
			dev_sel_q    <= 1'b0;
			chan_q       <= '0;
			wait_start_q <= '0;
			pending_q    <= 1'b0;
			err_flag_q   <= 1'b0;
			err_code_q   <= '0;
		end else if (fire) begin
			phase_q      <= phase_d;
			dev_sel_q    <= dev_sel_d;
			chan_q       <= chan_d;
			wait_start_q <= wait_start_d;
			pending_q    <= pending_d;
			err_flag_q   <= err_flag_d;
			err_code_q   <= err_code_d;
		end
	end

	// Hold the last read data for the cache step
	always_ff @(posedge clk) begin
		if (fire && capture) begin
			read_buf_q <= item.rx_data;
		end
	end

endmodule

`default_nettype wire

>>> src/dual_adc_scan_sequencer.sv
// Top level of the dual converter scan sequencer.
//
// Input channel (in_valid / in_stall) carries one event word: a poll, a
// transfer completion, a transfer error or a host cache read. Output channel
// (out_valid / out_stall) returns exactly one result word per event: the bus
// command to issue, the cache word stored, the host read data and status.
// The configuration channel (cfg_valid / cfg_ready) writes enabled, the two
// device addresses and the convert time; cfg_ready is always high.
// The accepted word sits in the input register, and the sequencer step loads
// the output register when it advances. Throughput is one word per cycle
// while out_stall is low; the step is a single pass through the phase logic.
// When out_stall is high the result word holds, the input register fills,
// and in_stall rises only once both are occupied.
// Reset clears the sequencer to the config phase of channel zero on device
// A, clears the cache and error status and loads the register defaults.
`default_nettype none

module dual_adc_scan_sequencer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	// Event input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  op,
	input  wire logic [31:0] now_ms,
	input  wire logic [15:0] rx_data,
	input  wire logic signed [7:0] error_code,
	input  wire logic [2:0]  read_index,
	// Result output channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       cmd_kind,
	output logic [6:0]       cmd_addr,
	output logic [7:0]       cmd_config_msb,
	output logic             cache_write,
	output logic [2:0]       cache_index,
	output logic [15:0]      cache_value,
	output logic [15:0]      host_data,
	output logic             busy_res,
	output logic             error_seen,
	output logic signed [7:0] last_error
);
	import dass_pkg::*;

	cfg_t        cfg_q;
	logic        valid_s1;
	item_t       item_s1;
	logic        valid_s2;
	res_t        res_s2;
	logic [15:0] host_s2;
	logic        advance;
	logic        in_take;
	res_t        step_res;
	logic [15:0] cache_rd;

	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled    <= 1'b1;
			cfg_q.addr_a     <= 7'd72;
			cfg_q.addr_b     <= 7'd73;
			cfg_q.convert_ms <= 8'd8;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ENABLED:    cfg_q.enabled    <= cfg_data[0];
				REG_ADDR_A:     cfg_q.addr_a     <= cfg_data[6:0];
				REG_ADDR_B:     cfg_q.addr_b     <= cfg_data[6:0];
				REG_CONVERT_MS: cfg_q.convert_ms <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Step the word in the input register when the output register frees up
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.op         <= op_t'(op);
			item_s1.now_ms     <= now_ms;
			item_s1.rx_data    <= rx_data;
			item_s1.error_code <= error_code;
			item_s1.read_index <= read_index;
		end
	end

	dass_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.item   (item_s1),
		.fire   (advance),
		.res    (step_res)
	);

	dass_cache u_cache (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (advance && step_res.cache_write),
		.wr_index (step_res.cache_index),
		.wr_data  (step_res.cache_value),
		.rd_index (item_s1.read_index),
		.rd_data  (cache_rd)
	);

	// Output register: load on advance, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2  <= step_res;
			host_s2 <= (item_s1.op == OP_HOST_READ) ? cache_rd : 16'd0;
		end
	end

	assign out_valid      = valid_s2;
	assign cmd_kind       = res_s2.cmd_kind;
	assign cmd_addr       = res_s2.cmd_addr;
	assign cmd_config_msb = res_s2.cmd_config_msb;
	assign cache_write    = res_s2.cache_write;
	assign cache_index    = res_s2.cache_index;
	assign cache_value    = res_s2.cache_value;
	assign host_data      = host_s2;
	assign busy_res       = res_s2.busy;
	assign error_seen     = res_s2.err_seen;
	assign last_error     = res_s2.last_error;

endmodule

`default_nettype wire

>>> src/dass_checker.sv
// Port-level checks of the scan sequencer and their bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module dass_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [1:0] cmd_kind,
	input wire logic       busy_res,
	input wire logic       error_seen
);
	import dass_pkg::*;

	logic out_take;
	logic busy_prev_q;
	logic seen_q;

	assign out_take = out_valid && !out_stall;

	// Track the busy flag and error flag of the last word taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_prev_q <= 1'b0;
			seen_q      <= 1'b0;
		end else if (out_take) begin
			busy_prev_q <= busy_res;
			seen_q      <= seen_q || error_seen;
		end
	end

	// An empty output register never backs up the input
	`ASSERT_IMPLY(a_idle_stall_low, clk, arst_n, !out_valid, !in_stall)
	// A command goes out only once the previous transfer has completed
	`ASSERT_IMPLY(a_cmd_needs_idle_bus, clk, arst_n, out_valid && cmd_kind != CMD_NONE, !busy_prev_q)
	// The error flag never falls once reported
	`ASSERT_IMPLY(a_error_sticky, clk, arst_n, out_valid && seen_q, error_seen)
	// A stalled word holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(cmd_kind) && $stable(busy_res))

endmodule

bind dual_adc_scan_sequencer dass_checker u_dass_checker (.*);

`default_nettype wire

>>> tb/dual_adc_scan_sequencer_checker.sv
`timescale 1ns / 1ps
// Checker for the scan sequencer: watches all channels, predicts each result word and compares.
module dual_adc_scan_sequencer_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [7:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [1:0]  op,
	input  wire logic [31:0] now_ms,
	input  wire logic [15:0] rx_data,
	input  wire logic signed [7:0] error_code,
	input  wire logic [2:0]  read_index,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [1:0]  cmd_kind,
	input  wire logic [6:0]  cmd_addr,
	input  wire logic [7:0]  cmd_config_msb,
	input  wire logic        cache_write,
	input  wire logic [2:0]  cache_index,
	input  wire logic [15:0] cache_value,
	input  wire logic [15:0] host_data,
	input  wire logic        busy_res,
	input  wire logic        error_seen,
	input  wire logic signed [7:0] last_error,
	output int               fail_count,
	output int               words_waiting,
	output logic             xfer_busy,
	output logic             read_unsafe
);
	import dass_pkg::*;

	typedef enum logic [2:0] {
		SCAN_CONFIG  = 3'd0,
		SCAN_POINTER = 3'd1,
		SCAN_WAIT    = 3'd2,
		SCAN_READ    = 3'd3,
		SCAN_STORE   = 3'd4
	} scan_phase_t;

	// Full result word as seen on the output ports
	typedef struct packed {
		cmd_t                cmd_kind;
		logic [6:0]          cmd_addr;
		logic [7:0]          cmd_config_msb;
		logic                cache_write;
		logic [CACHE_AW-1:0] cache_index;
		logic [15:0]         cache_value;
		logic [15:0]         host_data;
		logic                busy;
		logic                err_seen;
		logic signed [7:0]   last_error;
	} exp_t;

	// Shadow registers and sequencer state
	cfg_t              regs;
	scan_phase_t       scan_phase;
	logic              on_dev_b;
	logic [CHAN_W-1:0] chan;
	logic [31:0]       t_start;
	logic              pend;
	logic [15:0]       rbuf;
	logic              rbuf_loaded;
	logic              err_flag;
	logic signed [7:0] err_code;
	logic [15:0]       cache_words [CACHE_DEPTH];

	// Result words predicted but not yet seen, oldest first
	exp_t expected_q [$];
	exp_t got;
	exp_t want;

	// Let the stimulus keep transfers well formed
	assign xfer_busy   = pend;
	assign read_unsafe = pend && scan_phase == SCAN_STORE && !rbuf_loaded;

	// Advance the sequencer by one event and return the result word it gives
	function automatic exp_t scan_step(input op_t ev_op, input logic [31:0] t,
			input logic [15:0] rx, input logic signed [7:0] ec, input logic [2:0] ri);
		exp_t r;
		logic [6:0] dev;
		r = '0;
		dev = on_dev_b ? regs.addr_b : regs.addr_a;
		case (ev_op)
		OP_POLL: begin
			if (regs.enabled && !pend) begin
				case (scan_phase)
				SCAN_CONFIG: begin
					pend = 1'b1;
					r.cmd_kind = CMD_CONFIG;
					r.cmd_addr = dev;
					r.cmd_config_msb = MSB_TABLE[chan];
					if (on_dev_b)
						scan_phase = SCAN_POINTER;
					on_dev_b = !on_dev_b;
				end
				SCAN_POINTER: begin
					pend = 1'b1;
					r.cmd_kind = CMD_POINTER;
					r.cmd_addr = dev;
					// start the conversion clock after the second device
					if (on_dev_b) begin
						t_start = t;
						scan_phase = SCAN_WAIT;
					end
					on_dev_b = !on_dev_b;
				end
				SCAN_WAIT: begin
					// wrapping elapsed time, strictly greater
					if ((t - t_start) > {24'd0, regs.convert_ms})
						scan_phase = SCAN_READ;
				end
				SCAN_READ: begin
					pend = 1'b1;
					r.cmd_kind = CMD_READ;
					r.cmd_addr = dev;
					scan_phase = SCAN_STORE;
				end
				SCAN_STORE: begin
					r.cache_write = 1'b1;
					r.cache_value = rbuf;
					if (!on_dev_b) begin
						r.cache_index = CACHE_AW'(chan);
						scan_phase = SCAN_READ;
					end else begin
						r.cache_index = CACHE_AW'(chan + CHANNELS);
						chan = (chan == CHAN_W'(CHANNELS - 1)) ? '0 : chan + 1'b1;
						scan_phase = SCAN_CONFIG;
					end
					on_dev_b = !on_dev_b;
					cache_words[r.cache_index] = rbuf;
				end
				default: begin
					scan_phase = SCAN_CONFIG;
				end
				endcase
			end
		end
		OP_DONE: begin
			// capture read data only for a pending read
			if (pend && scan_phase == SCAN_STORE) begin
				rbuf = rx;
				rbuf_loaded = 1'b1;
			end
			pend = 1'b0;
		end
		OP_ERROR: begin
			pend = 1'b0;
			err_flag = 1'b1;
			err_code = ec;
		end
		OP_HOST_READ: begin
			r.host_data = cache_words[ri];
		end
		endcase
		r.busy = pend;
		r.err_seen = err_flag;
		r.last_error = err_code;
		return r;
	endfunction

	function automatic string show_word(input exp_t w);
		return {$sformatf("kind=%0d addr=%0d msb=%02h wr=%0b idx=%0d val=%04h host=%04h",
			w.cmd_kind, w.cmd_addr, w.cmd_config_msb, w.cache_write, w.cache_index,
			w.cache_value, w.host_data),
			$sformatf(" busy=%0b err=%0b code=%0d", w.busy, w.err_seen, w.last_error)};
	endfunction

	// Check result words, track register writes, predict accepted event words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.enabled = 1'b1;
			regs.addr_a = 7'd72;
			regs.addr_b = 7'd73;
			regs.convert_ms = 8'd8;
			scan_phase = SCAN_CONFIG;
			on_dev_b = 1'b0;
			chan = '0;
			t_start = '0;
			pend = 1'b0;
			rbuf = '0;
			rbuf_loaded = 1'b0;
			err_flag = 1'b0;
			err_code = '0;
			for (int i = 0; i < CACHE_DEPTH; i++)
				cache_words[i] = '0;
			expected_q.delete();
			fail_count = 0;
			words_waiting = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = '{cmd_t'(cmd_kind), cmd_addr, cmd_config_msb, cache_write, cache_index,
					cache_value, host_data, busy_res, error_seen, last_error};
				if (expected_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result word with none expected: %s", $time,
							show_word(got));
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: mismatch\n  expected %s\n  actual   %s", $time,
								show_word(want), show_word(got));
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				REG_ENABLED:    regs.enabled = cfg_data[0];
				REG_ADDR_A:     regs.addr_a = cfg_data[6:0];
				REG_ADDR_B:     regs.addr_b = cfg_data[6:0];
				REG_CONVERT_MS: regs.convert_ms = cfg_data;
				default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_q.push_back(scan_step(op_t'(op), now_ms, rx_data, error_code,
					read_index));
			words_waiting = expected_q.size();
		end
	end

endmodule

>>> tb/dual_adc_scan_sequencer_tb.sv
`timescale 1ns / 1ps
// Testbench top for the scan sequencer: clock, reset, stimulus, idling and verdict.
module dual_adc_scan_sequencer_tb;
	import dass_pkg::*;

	localparam int RUN_LIMIT = 200000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [7:0]        cfg_index = '0;
	logic [7:0]        cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        op = OP_POLL;
	logic [31:0]       now_ms = '0;
	logic [15:0]       rx_data = '0;
	logic signed [7:0] error_code = '0;
	logic [2:0]        read_index = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [1:0]        cmd_kind;
	logic [6:0]        cmd_addr;
	logic [7:0]        cmd_config_msb;
	logic              cache_write;
	logic [2:0]        cache_index;
	logic [15:0]       cache_value;
	logic [15:0]       host_data;
	logic              busy_res;
	logic              error_seen;
	logic signed [7:0] last_error;

	int   fail_count;
	int   words_waiting;
	logic xfer_busy;
	logic read_unsafe;

	// Idling odds in percent, current settings and the millisecond clock
	int          gap_pct = 0;
	int          stall_pct = 0;
	int          cycle_count = 0;
	logic        en = 1'b1;
	int          conv_ms = 8;
	logic [31:0] ms_now = '0;

	dual_adc_scan_sequencer DUT (.*);

	dual_adc_scan_sequencer_checker seq_check (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Stall the result channel at random
	always @(negedge clk)
		out_stall <= ($urandom_range(0, 99) < stall_pct);

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("** dual_adc_scan_sequencer: FAILED **");
			$finish;
		end
	end

	// Offer one event word, idling first at random; return on the falling edge after accept
	task automatic push_event(input op_t o, input logic [31:0] t, input logic [15:0] rx,
			input logic [7:0] ec, input logic [2:0] ri);
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		now_ms <= t;
		rx_data <= rx;
		error_code <= ec;
		read_index <= ri;
		// hold the word until it is taken
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Drop valid and wait until every predicted word has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (words_waiting != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Mostly well-formed transfers: answer a pending command, otherwise poll
	task automatic run_random(input int target);
		int          counted;
		int          roll;
		op_t         o;
		logic [31:0] t;
		counted = 0;
		while (counted < target) begin
			roll = $urandom_range(0, 99);
			t = $urandom;
			if (xfer_busy) begin
				if (roll < 80)
					o = OP_DONE;
				else if (roll < 88 && !read_unsafe)
					o = OP_ERROR;
				else if (roll < 94)
					o = OP_POLL;
				else
					o = OP_HOST_READ;
			end else begin
				if (roll < 78)
					o = OP_POLL;
				else if (roll < 90)
					o = OP_HOST_READ;
				else if (roll < 95)
					o = OP_DONE;
				else
					o = OP_ERROR;
			end
			// advance the millisecond clock on polls, with a rare large jump
			if (o == OP_POLL) begin
				if ($urandom_range(0, 99) < 3)
					ms_now += $urandom;
				else
					ms_now += $urandom_range(0, conv_ms / 2 + 2);
				t = ms_now;
			end
			if (!(o == OP_POLL && (xfer_busy || !en)))
				counted++;
			push_event(o, t, 16'($urandom), 8'($urandom), 3'($urandom));
		end
	endtask

	initial begin
		logic [6:0] adr_a;
		logic [6:0] adr_b;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int p = 0; p < 8; p++) begin
			case (p % 4)
			0: begin
				gap_pct = 0;
				stall_pct = 0;
			end
			1: begin
				gap_pct = 45;
				stall_pct = 0;
			end
			2: begin
				gap_pct = 0;
				stall_pct = 45;
			end
			default: begin
				gap_pct = 8;
				stall_pct = 8;
			end
			endcase
			if (p == 0) begin
				// host reads of the cleared cache, lowest and highest word
				push_event(OP_HOST_READ, 32'h0, 16'h0, 8'h00, 3'd0);
				push_event(OP_HOST_READ, 32'hFFFF_FFFF, 16'hFFFF, 8'h7F, 3'd7);
				// stray completion must not capture data; stray error latches its code
				push_event(OP_DONE, 32'h0, 16'hFFFF, 8'h00, 3'd0);
				push_event(OP_ERROR, 32'h0, 16'h0, 8'h80, 3'd0);
				// config to A, a poll ignored while pending, then config to B that fails
				push_event(OP_POLL, 32'hFFFF_FFF0, 16'h0, 8'h00, 3'd0);
				push_event(OP_POLL, 32'hFFFF_FFF0, 16'h0, 8'h00, 3'd0);
				push_event(OP_DONE, 32'h0, 16'h1234, 8'h00, 3'd0);
				push_event(OP_POLL, 32'hFFFF_FFF1, 16'h0, 8'h00, 3'd0);
				push_event(OP_ERROR, 32'h0, 16'h0, 8'h7F, 3'd0);
				// pointer to A and B; B starts the conversion clock just before the wrap
				push_event(OP_POLL, 32'hFFFF_FFF2, 16'h0, 8'h00, 3'd0);
				push_event(OP_DONE, 32'h0, 16'h0, 8'h00, 3'd0);
				push_event(OP_POLL, 32'hFFFF_FFFC, 16'h0, 8'h00, 3'd0);
				push_event(OP_DONE, 32'h0, 16'h0, 8'h00, 3'd0);
				// elapsed equal to the convert time holds, one more releases
				push_event(OP_POLL, 32'h0000_0004, 16'h0, 8'h00, 3'd0);
				push_event(OP_POLL, 32'h0000_0005, 16'h0, 8'h00, 3'd0);
				// read and store A, then B
				push_event(OP_POLL, 32'h0000_0005, 16'h0, 8'h00, 3'd0);
				push_event(OP_DONE, 32'h0, 16'hFFFF, 8'h00, 3'd0);
				push_event(OP_POLL, 32'h0000_0005, 16'h0, 8'h00, 3'd0);
				push_event(OP_POLL, 32'h0000_0005, 16'h0, 8'h00, 3'd0);
				push_event(OP_DONE, 32'h0, 16'h0000, 8'h00, 3'd0);
				push_event(OP_POLL, 32'h0000_0005, 16'h0, 8'h00, 3'd0);
				push_event(OP_HOST_READ, 32'h0, 16'h0, 8'h00, 3'd0);
				push_event(OP_HOST_READ, 32'h0, 16'h0, 8'h00, 3'd4);
				ms_now = 32'd5;
				run_random(110);
			end else begin
				// reconfigure only with nothing in flight
				wait_drained();
				en = (p != 3);
				case (p)
				1: begin
					adr_a = 7'd0;
					adr_b = 7'd127;
					conv_ms = 0;
				end
				2: begin
					adr_a = 7'd127;
					adr_b = 7'd0;
					conv_ms = 255;
				end
				4: begin
					adr_a = 7'($urandom);
					adr_b = 7'($urandom);
					conv_ms = 1;
				end
				default: begin
					adr_a = 7'($urandom);
					adr_b = 7'($urandom);
					conv_ms = $urandom_range(0, 31);
				end
				endcase
				write_reg(REG_ENABLED, {7'd0, en});
				write_reg(REG_ADDR_A, {1'b0, adr_a});
				write_reg(REG_ADDR_B, {1'b0, adr_b});
				write_reg(REG_CONVERT_MS, 8'(conv_ms));
				ms_now = (p == 1) ? 32'hFFFF_FFC0 : $urandom;
				run_random(en ? 125 : 25);
			end
		end
		wait_drained();
		repeat (8) @(negedge clk);
		if (fail_count == 0) begin
			$display("** dual_adc_scan_sequencer: PASSED **");
		end else begin
			$display("** dual_adc_scan_sequencer: FAILED **");
		end
		$finish;
	end

endmodule

>>> dual_adc_scan_sequencer.f
+incdir+src
src/dass_pkg.sv
src/dass_cache.sv
src/dass_seq.sv
src/dual_adc_scan_sequencer.sv
src/dass_checker.sv
tb/dual_adc_scan_sequencer_checker.sv
tb/dual_adc_scan_sequencer_tb.sv
